// ===== src/sbpr_pkg.sv =====
// Shared types, codes and constants of the shunt balance PWM regulator.
package sbpr_pkg;

    // Field and register widths
    localparam int unsigned MV_W       = 16;
    localparam int unsigned TEMP_W     = 8;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned QUOT_W     = 8;
    localparam int unsigned DIV_CNT_W  = $clog2(QUOT_W);

    // Reset values of the configuration registers
    localparam logic [MV_W-1:0]   VOLT_MIN_RESET  = 16'd0;
    localparam logic [MV_W-1:0]   VOLT_MAX_RESET  = 16'd65535;
    localparam logic [TEMP_W-1:0] TEMP_LOW_RESET  = 8'd0;
    localparam logic [TEMP_W-1:0] TEMP_HIGH_RESET = 8'd255;
    localparam logic [CNT_W-1:0]  LOOP_RESET      = 16'd100;
    localparam logic [CNT_W-1:0]  IDLE_RESET      = 16'd30000;
    localparam logic [DUTY_W-1:0] DUTY_FULL       = 8'd255;

    // Command codes carried with each input word
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_STATUS = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_STOP   = 2'd3
    } t_func;

    // Run status codes
    typedef enum logic [1:0] {
        RUN_OFF   = 2'd0,
        RUN_IDLE  = 2'd1,
        RUN_ON    = 2'd2,
        RUN_LIMIT = 2'd3
    } t_run;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLT_MIN   = 3'd0,
        CFG_VOLT_MAX   = 3'd1,
        CFG_TEMP_LOW   = 3'd2,
        CFG_TEMP_HIGH  = 3'd3,
        CFG_LOOP       = 3'd4,
        CFG_IDLE_LIMIT = 3'd5
    } t_cfg_idx;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_EXEC  = 3'd1,
        S_VOLT  = 3'd2,
        S_VDIV  = 3'd3,
        S_TEMP  = 3'd4,
        S_TDIV  = 3'd5,
        S_APPLY = 3'd6,
        S_OUT   = 3'd7
    } t_state;

    // Divider operand select
    typedef enum logic {
        DSEL_VOLT = 1'b0,
        DSEL_TEMP = 1'b1
    } t_dsel;

    // Controller to datapath commands
    typedef struct packed {
        logic  load_in;
        logic  exec;
        logic  volt;
        logic  take_v;
        logic  temp;
        logic  take_t;
        logic  apply;
        logic  out_load;
        logic  div_start;
        t_dsel dsel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pass;
        logic need_vdiv;
        logic need_tdiv;
    } t_stat;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== src/sbpr_div.sv =====
// Radix-2 restoring divider for (num * 256) / den with num below den.
module sbpr_div import sbpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MV_W-1:0]   i_num,
    input  logic [MV_W-1:0]   i_den,
    output logic [QUOT_W-1:0] o_quot,
    output t_div_stat         o_stat
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [MV_W-1:0]      r_rem, n_rem;
    logic [MV_W-1:0]      r_den, n_den;
    logic [QUOT_W-1:0]    r_quot, n_quot;
    logic [MV_W:0]        rem2;
    logic [MV_W:0]        diff;
    logic                 ge;

    // One quotient bit per cycle
    always_comb begin
        rem2   = {r_rem, 1'b0};
        diff   = rem2 - {1'b0, r_den};
        ge     = rem2 >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_den  = i_den;
            n_quot = '0;
        end else if (r_busy) begin
            // remainder stays below den, so it fits the narrow register
            n_rem  = ge ? diff[MV_W-1:0] : rem2[MV_W-1:0];
            n_quot = {r_quot[QUOT_W-2:0], ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(QUOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== src/sbpr_dp.sv =====
// Datapath: configuration, countdowns, target and duty computation, result register.
module sbpr_dp import sbpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_func,
    input  logic [MV_W-1:0]       i_cell_mv,
    input  logic [TEMP_W-1:0]     i_temp_c,
    input  t_cmd                  i_cmd,
    input  logic [QUOT_W-1:0]     i_quot,
    output t_stat                 o_stat,
    output logic [MV_W-1:0]       o_div_num,
    output logic [MV_W-1:0]       o_div_den,
    output logic [DUTY_W-1:0]     o_duty,
    output logic [1:0]            o_status
);

    // Configuration registers
    logic [MV_W-1:0]   r_volt_min, r_volt_max;
    logic [TEMP_W-1:0] r_temp_low, r_temp_high;
    logic [CNT_W-1:0]  r_loop_period, r_idle_limit;

    // Held input word
    t_func             r_func;
    logic [MV_W-1:0]   r_v;
    logic [TEMP_W-1:0] r_t;

    // Regulator state
    logic [DUTY_W-1:0] r_duty, n_duty;
    t_run              r_run, n_run;
    logic [CNT_W-1:0]  r_loop_cd, n_loop_cd;
    logic [CNT_W-1:0]  r_idle_cd, n_idle_cd;
    logic [DUTY_W-1:0] r_target, n_target;
    t_run              r_st, n_st;
    logic [CNT_W-1:0]  loop_dec;

    // Result register
    logic [DUTY_W-1:0] r_out_duty;
    t_run              r_out_status;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_min    <= VOLT_MIN_RESET;
            r_volt_max    <= VOLT_MAX_RESET;
            r_temp_low    <= TEMP_LOW_RESET;
            r_temp_high   <= TEMP_HIGH_RESET;
            r_loop_period <= LOOP_RESET;
            r_idle_limit  <= IDLE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_VOLT_MIN:   r_volt_min    <= i_cfg_data[MV_W-1:0];
                CFG_VOLT_MAX:   r_volt_max    <= i_cfg_data[MV_W-1:0];
                CFG_TEMP_LOW:   r_temp_low    <= i_cfg_data[TEMP_W-1:0];
                CFG_TEMP_HIGH:  r_temp_high   <= i_cfg_data[TEMP_W-1:0];
                CFG_LOOP:       r_loop_period <= i_cfg_data[CNT_W-1:0];
                CFG_IDLE_LIMIT: r_idle_limit  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= t_func'(i_func);
            r_v    <= i_cell_mv;
            r_t    <= i_temp_c;
        end
    end

    // Status toward the controller
    always_comb begin
        o_stat.pass      = (r_func == FUNC_TICK) && (r_run != RUN_OFF) &&
                           (r_loop_cd <= 16'd1);
        o_stat.need_vdiv = (r_v > r_volt_min) && (r_v < r_volt_max);
        o_stat.need_tdiv = (r_target != '0) && (r_t > r_temp_low) &&
                           (r_t < r_temp_high);
    end

    // Divider operands; both give a quotient below 256
    always_comb begin
        if (i_cmd.dsel == DSEL_TEMP) begin
            o_div_num = {{(MV_W-TEMP_W){1'b0}}, r_temp_high - r_t};
            o_div_den = {{(MV_W-TEMP_W){1'b0}}, r_temp_high - r_temp_low};
        end else begin
            o_div_num = r_v - r_volt_min;
            o_div_den = r_volt_max - r_volt_min;
        end
    end

    // Next state of the regulator
    always_comb begin
        n_duty    = r_duty;
        n_run     = r_run;
        n_loop_cd = r_loop_cd;
        n_idle_cd = r_idle_cd;
        n_target  = r_target;
        n_st      = r_st;
        loop_dec  = (r_loop_cd != '0) ? r_loop_cd - 1'b1 : '0;
        if (i_cmd.exec) begin
            unique case (r_func)
                FUNC_TICK: begin
                    if (r_run == RUN_OFF) begin
                        n_duty = '0;
                    end else begin
                        n_idle_cd = (r_idle_cd != '0) ? r_idle_cd - 1'b1 : '0;
                        if (loop_dec == '0) begin
                            n_loop_cd = (r_loop_period == '0) ? 16'd1 : r_loop_period;
                        end else begin
                            n_loop_cd = loop_dec;
                        end
                    end
                end
                FUNC_STATUS: begin
                    n_idle_cd = r_idle_limit;
                end
                FUNC_START: begin
                    n_duty    = '0;
                    n_idle_cd = r_idle_limit;
                    n_loop_cd = 16'd1;
                    n_run     = RUN_IDLE;
                end
                FUNC_STOP: begin
                    n_duty = '0;
                    n_run  = RUN_OFF;
                end
            endcase
        end else if (i_cmd.volt) begin
            // classify the voltage; the in-band target comes from the divider
            if (r_v <= r_volt_min) begin
                n_target = '0;
                n_st     = RUN_IDLE;
            end else if (r_v >= r_volt_max) begin
                n_target = DUTY_FULL;
                n_st     = RUN_ON;
            end else begin
                n_target = '0;
                n_st     = RUN_ON;
            end
        end else if (i_cmd.take_v) begin
            n_target = i_quot;
        end else if (i_cmd.temp) begin
            // hot board: force the target off
            if ((r_target != '0) && (r_t >= r_temp_high)) begin
                n_target = '0;
                n_st     = RUN_LIMIT;
            end
        end else if (i_cmd.take_t) begin
            // lower the target to the temperature cap
            if (r_target > i_quot) begin
                n_target = i_quot;
                n_st     = RUN_LIMIT;
            end
        end else if (i_cmd.apply) begin
            if (r_idle_cd == '0) begin
                n_duty = '0;
                n_run  = RUN_OFF;
            end else begin
                if (r_target > r_duty) begin
                    n_duty = r_duty + 1'b1;
                end else if (r_target < r_duty) begin
                    n_duty = r_duty - 1'b1;
                end
                n_run = r_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty    <= '0;
            r_run     <= RUN_OFF;
            r_loop_cd <= '0;
            r_idle_cd <= '0;
        end else begin
            r_duty    <= n_duty;
            r_run     <= n_run;
            r_loop_cd <= n_loop_cd;
            r_idle_cd <= n_idle_cd;
        end
    end

    // Hold target, pass status and the result word
    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_st     <= n_st;
        if (i_cmd.out_load) begin
            r_out_duty   <= r_duty;
            r_out_status <= r_run;
        end
    end

    assign o_duty   = r_out_duty;
    assign o_status = r_out_status;

`ifndef NO_ASSERTIONS
    // An expired idle countdown shuts the block down at a pass
    a_idle_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && (r_idle_cd == '0)) |=> ((r_run == RUN_OFF) && (r_duty == '0)))
        else $error("pass with expired idle countdown did not stop");

    // A pass moves the duty by at most one step
    a_duty_slew: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && (r_idle_cd != '0)) |=>
        ((r_duty == $past(r_duty)) || (r_duty == $past(r_duty) + 8'd1) ||
         (r_duty == $past(r_duty) - 8'd1)))
        else $error("duty moved more than one step");

    // A tick while off keeps the duty at zero
    a_off_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_func == FUNC_TICK) && (r_run == RUN_OFF)) |=>
        ((r_duty == '0) && (r_run == RUN_OFF)))
        else $error("tick while off changed the regulator");
`endif

endmodule

// ===== src/sbpr_ctrl.sv =====
// Controller: sequences one input word through command, pass and result steps.
module sbpr_ctrl import sbpr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    input  t_stat     i_stat,
    input  t_div_stat i_div,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.dsel  = DSEL_VOLT;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.pass ? S_VOLT : S_OUT;
            end
            S_VOLT: begin
                o_cmd.volt = 1'b1;
                if (i_stat.need_vdiv) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_VDIV;
                end else begin
                    n_state = S_TEMP;
                end
            end
            S_VDIV: begin
                if (i_div.done) begin
                    o_cmd.take_v = 1'b1;
                    n_state      = S_TEMP;
                end
            end
            S_TEMP: begin
                o_cmd.temp = 1'b1;
                if (i_stat.need_tdiv) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.dsel      = DSEL_TEMP;
                    n_state         = S_TDIV;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_TDIV: begin
                o_cmd.dsel = DSEL_TEMP;
                if (i_div.done) begin
                    o_cmd.take_t = 1'b1;
                    n_state      = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    // An accepted word always goes to command execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted word not executed");

    // While waiting on a quotient the divider is running or finished
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_VDIV) || (r_state == S_TDIV)) |-> (i_div.busy || i_div.done))
        else $error("waiting on an idle divider");

    // A new result only appears from the result step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result valid raised outside result step");
`endif

endmodule

// ===== src/shunt_balance_pwm_regulator_top.sv =====
// Sequence: start, stop and status words and ticks without a pass go from accept through the command
// step to the result step. A tick with a regulation pass adds at most two divisions in the shared
// radix-2 divider plus the voltage, temperature and apply steps of the controller.
// A new word is taken only once the result of the last one is loaded into the result register.
// Reset (synchronous, active low): status off, duty 0, countdowns 0, registers
// to their defaults; no clearing pass.
module shunt_balance_pwm_regulator_top import sbpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // cell_mv[15:0], temp_c[23:16]
    input  logic [1:0]            s_axis_tuser,  // func[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // duty[7:0], status[9:8], zero fill
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd              cmd;
    t_stat             stat;
    t_div_stat         div_stat;
    logic [MV_W-1:0]   div_num, div_den;
    logic [QUOT_W-1:0] quot;
    logic [DUTY_W-1:0] duty;
    logic [1:0]        status;

    assign o_cfg_ready = 1'b1;

    sbpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .i_div       (div_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    sbpr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_func      (s_axis_tuser),
        .i_cell_mv   (s_axis_tdata[15:0]),
        .i_temp_c    (s_axis_tdata[23:16]),
        .i_cmd       (cmd),
        .i_quot      (quot),
        .o_stat      (stat),
        .o_div_num   (div_num),
        .o_div_den   (div_den),
        .o_duty      (duty),
        .o_status    (status)
    );

    sbpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (quot),
        .o_stat  (div_stat)
    );

    assign m_axis_tdata = {6'd0, status, duty};

endmodule
